### src/esfr_pkg.sv
// ----------------------------------------------------------------------------
// Escaped serial frame receiver package
// Shared types and constants for the frame receiver modules.
// ----------------------------------------------------------------------------
package esfr_pkg;

    localparam logic [7:0] SYNC_BYTE    = 8'hE0;
    localparam logic [7:0] ESC_BYTE     = 8'hD0;
    localparam int         HEADER_BYTES = 5;

    localparam int POS_W = 9;

    localparam logic [2:0] POS_LENGTH  = 3'd1;
    localparam logic [2:0] POS_ADDRESS = 3'd2;
    localparam logic [2:0] POS_SEQ     = 3'd3;
    localparam logic [2:0] POS_COMMAND = 3'd4;

    typedef enum logic [2:0] {
        EV_PAYLOAD  = 3'd0,
        EV_GOOD     = 3'd1,
        EV_BAD      = 3'd2,
        EV_SYNC     = 3'd3,
        EV_OVERFLOW = 3'd4
    } t_event;

    typedef struct packed {
        logic [7:0] payload_length;
        logic [7:0] command;
        logic [7:0] sequence_res;
        logic [7:0] address;
        logic [7:0] frame_length;
        logic [7:0] payload_index;
        logic [7:0] data_byte;
        t_event     event_res;
    } t_result;

endpackage

### src/escaped_serial_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// Escaped serial frame receiver
// Rebuilds sync-byte framed, escaped request frames from a byte stream.
// ----------------------------------------------------------------------------
// One received byte per beat is accepted every clock cycle while the result
// side keeps up; each byte passes an input register and the frame decoder,
// which updates position, escape and checksum, and its result is held in the
// result register. A payload byte, a frame good or bad event, a sync error or
// a length overflow each give one result beat; other bytes give none. When the
// result register is stalled the input stops after one further byte is held.
module escaped_serial_frame_receiver_unit
    import esfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // data_byte, payload_index, frame_length, address, sequence_res, command,
    // payload_length
    output logic [55:0] m_tdata,
    output logic [2:0]  m_tuser    // event_res
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_free;
    logic       advance;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign advance = in_valid && out_free;

    esfr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_tvalid),
        .o_ready   (s_tready),
        .i_byte    (s_tdata),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    esfr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    esfr_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_ready     (m_tready),
        .o_free      (out_free),
        .o_valid     (m_tvalid),
        .o_res       (out_res)
    );

    assign m_tuser = out_res.event_res;
    assign m_tdata = {out_res.payload_length, out_res.command, out_res.sequence_res,
                      out_res.address, out_res.frame_length, out_res.payload_index,
                      out_res.data_byte};

endmodule

### src/esfr_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one received byte until the frame logic takes it.
// ----------------------------------------------------------------------------
module esfr_in_reg
    import esfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

### src/esfr_core.sv
// ----------------------------------------------------------------------------
// Frame decoder
// Tracks frame position, escape and checksum, and forms at most one result per byte.
// ----------------------------------------------------------------------------
module esfr_core
    import esfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_esc, n_esc;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_addr, n_addr;
    logic [7:0]       r_seq, n_seq;
    logic [7:0]       r_cmd, n_cmd;
    logic [7:0]       r_plen, n_plen;

    logic             take;
    logic [7:0]       d;
    logic [POS_W-1:0] frame_end;
    logic [POS_W-1:0] idx_full;

    assign frame_end = {1'b0, r_len} + POS_W'(1);
    assign idx_full  = r_pos - POS_W'(HEADER_BYTES + 1);

    always_comb begin
        n_pos       = r_pos;
        n_esc       = r_esc;
        n_sum       = r_sum;
        n_len       = r_len;
        n_addr      = r_addr;
        n_seq       = r_seq;
        n_cmd       = r_cmd;
        n_plen      = r_plen;
        take        = 1'b0;
        d           = i_byte;
        o_res_valid = 1'b0;
        o_res.event_res     = EV_PAYLOAD;
        o_res.data_byte     = 8'd0;
        o_res.payload_index = 8'd0;

        if (r_pos == '0) begin
            if (i_byte == SYNC_BYTE) begin
                n_pos  = POS_W'(1);
                n_esc  = 1'b0;
                n_sum  = 8'd0;
                n_len  = 8'd0;
                n_addr = 8'd0;
                n_seq  = 8'd0;
                n_cmd  = 8'd0;
                n_plen = 8'd0;
            end
        end else if (r_esc) begin
            n_esc = 1'b0;
            d     = i_byte + 8'd1;
            take  = 1'b1;
        end else if (i_byte == SYNC_BYTE) begin
            n_pos           = '0;
            o_res_valid     = 1'b1;
            o_res.event_res = EV_SYNC;
        end else if (i_byte == ESC_BYTE) begin
            n_esc = 1'b1;
        end else begin
            take = 1'b1;
        end

        if (take) begin
            if (r_pos <= POS_W'(HEADER_BYTES)) begin
                case (r_pos[2:0])
                    POS_LENGTH:  n_len  = d;
                    POS_ADDRESS: n_addr = d;
                    POS_SEQ:     n_seq  = d;
                    POS_COMMAND: n_cmd  = d;
                    default:     n_plen = d;
                endcase
                n_sum = r_sum + d;
                n_pos = r_pos + POS_W'(1);
            end else if (r_pos > frame_end) begin
                n_pos           = '0;
                o_res_valid     = 1'b1;
                o_res.event_res = EV_OVERFLOW;
            end else if (r_pos == frame_end) begin
                n_pos           = '0;
                o_res_valid     = 1'b1;
                o_res.event_res = (d == r_sum) ? EV_GOOD : EV_BAD;
            end else begin
                n_sum               = r_sum + d;
                n_pos               = r_pos + POS_W'(1);
                o_res_valid         = 1'b1;
                o_res.event_res     = EV_PAYLOAD;
                o_res.data_byte     = d;
                o_res.payload_index = idx_full[7:0];
            end
        end

        o_res.frame_length   = n_len;
        o_res.address        = n_addr;
        o_res.sequence_res   = n_seq;
        o_res.command        = n_cmd;
        o_res.payload_length = n_plen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_esc  <= 1'b0;
            r_sum  <= 8'd0;
            r_len  <= 8'd0;
            r_addr <= 8'd0;
            r_seq  <= 8'd0;
            r_cmd  <= 8'd0;
            r_plen <= 8'd0;
        end else if (i_en) begin
            r_pos  <= n_pos;
            r_esc  <= n_esc;
            r_sum  <= n_sum;
            r_len  <= n_len;
            r_addr <= n_addr;
            r_seq  <= n_seq;
            r_cmd  <= n_cmd;
            r_plen <= n_plen;
        end
    end

endmodule

### src/esfr_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module esfr_out_reg
    import esfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

### src/esfr_checker.sv
// ----------------------------------------------------------------------------
// Frame receiver port checker
// Checks the result stream of the frame receiver as seen on its ports.
// ----------------------------------------------------------------------------
module esfr_checker
    import esfr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [2:0]  m_tuser
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat withdrawn while stalled");

    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tuser <= EV_OVERFLOW)
        else $error("unknown event code");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser != EV_PAYLOAD |-> m_tdata[15:0] == 16'd0)
        else $error("data or index set on a frame event");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == EV_PAYLOAD |-> m_tdata[15:8] < m_tdata[23:16])
        else $error("payload index beyond frame length");

endmodule

bind escaped_serial_frame_receiver_unit esfr_checker u_esfr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
